// ===== sv/indexed_linked_list_engine_unit_macros.svh =====
// Assertion macros for the indexed linked list engine.
`ifndef INDEXED_LINKED_LIST_ENGINE_UNIT_MACROS_SVH
`define INDEXED_LINKED_LIST_ENGINE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ILST_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("concurrent assertion failed");
`define ILST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("concurrent assertion failed");
`else
`define ILST_ASSERT_IMPL(label, ante, cons)
`define ILST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== sv/ilst_pkg.sv =====
// Shared constants, codes and interface types of the indexed linked list engine.
package ilst_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int COUNT_W    = 11;
    localparam int CMD_W      = 3;
    localparam int IO_VALUE_W = 32;

    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [COUNT_W-1:0]    t_count;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_AT   = 3'd3,
        CMD_DELETE   = 3'd4
    } t_cmd;

    typedef struct packed {
        logic   rd_en;
        t_slot  rd_addr;
        logic   wr_val_en;
        logic   wr_link_en;
        t_slot  wr_addr;
        t_value wr_val;
        t_slot  wr_link;
    } t_mem_req;

    typedef struct packed {
        t_value value;
        t_slot  link;
    } t_mem_rsp;

    typedef struct packed {
        logic   valid;
        logic   ok;
        t_value rv;
        t_count count;
    } t_result;

endpackage

// ===== sv/ilst_node_mem.sv =====
// Node store: value memory and next-link memory with registered read data.
module ilst_node_mem import ilst_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_mem_rsp o_rsp
);

    t_value r_values [CAPACITY];
    t_slot  r_links  [CAPACITY];
    t_value r_rd_value;
    t_slot  r_rd_link;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_val_en) begin
            r_values[i_req.wr_addr] <= i_req.wr_val;
        end
        if (i_req.wr_link_en) begin
            r_links[i_req.wr_addr] <= i_req.wr_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_value <= r_values[i_req.rd_addr];
            r_rd_link  <= r_links[i_req.rd_addr];
        end
    end

    assign o_rsp.value = r_rd_value;
    assign o_rsp.link  = r_rd_link;

endmodule

// ===== sv/ilst_ctrl.sv =====
// Command sequencer: slot allocation, link walk, read-modify-write of the node store.
module ilst_ctrl import ilst_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [CMD_W-1:0]             i_cmd,
    input  logic [COUNT_W-1:0]           i_position,
    input  logic signed [IO_VALUE_W-1:0] i_item_value,
    input  logic                         i_out_free,
    output t_result                      o_res,
    output t_mem_req                     o_mem_req,
    input  t_mem_rsp                     i_mem_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC,
        S_ALLOC_WAIT,
        S_WALK,
        S_FETCH,
        S_USE,
        S_WR1,
        S_WR2,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        OP_READ,
        OP_PUT_HEAD,
        OP_PUT_TAIL,
        OP_PUT_MID,
        OP_DELETE
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    t_slot  r_head, n_head;
    t_slot  r_tail, n_tail;
    t_count r_count, n_count;
    t_count r_fresh, n_fresh;
    t_slot  r_fhead, n_fhead;
    t_count r_fcount, n_fcount;
    t_count r_steps, n_steps;
    logic   r_pend, n_pend;
    logic   r_at_head, n_at_head;
    t_slot  r_cur, n_cur;
    t_slot  r_prev, n_prev;
    t_slot  r_new, n_new;
    t_slot  r_nn, n_nn;
    t_value r_v, n_v;
    logic   r_res_ok, n_res_ok;
    t_value r_res_rv, n_res_rv;

    t_slot    cur_now;
    logic     full;
    t_mem_req req;

    assign cur_now = r_pend ? i_mem_rsp.link : r_cur;
    assign full    = r_count >= COUNT_W'(CAPACITY);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_fresh   = r_fresh;
        n_fhead   = r_fhead;
        n_fcount  = r_fcount;
        n_steps   = r_steps;
        n_pend    = r_pend;
        n_at_head = r_at_head;
        n_cur     = r_cur;
        n_prev    = r_prev;
        n_new     = r_new;
        n_nn      = r_nn;
        n_v       = r_v;
        n_res_ok  = r_res_ok;
        n_res_rv  = r_res_rv;
        req       = '0;
        o_res     = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_v       = t_value'(i_item_value);
                    n_cur     = r_head;
                    n_pend    = 1'b0;
                    n_steps   = i_position;
                    n_at_head = (i_position == '0);
                    n_res_ok  = 1'b0;
                    n_res_rv  = '0;
                    n_state   = S_RESP;
                    unique case (t_cmd'(i_cmd))
                        CMD_READ: begin
                            if (i_position < r_count) begin
                                n_op     = OP_READ;
                                n_res_ok = 1'b1;
                                n_state  = S_WALK;
                            end else begin
                                n_res_rv = '1;
                            end
                        end
                        CMD_INS_HEAD: begin
                            if (!full) begin
                                n_op     = OP_PUT_HEAD;
                                n_res_ok = 1'b1;
                                n_state  = S_ALLOC;
                            end
                        end
                        CMD_INS_TAIL: begin
                            if (!full) begin
                                n_op     = OP_PUT_TAIL;
                                n_res_ok = 1'b1;
                                n_state  = S_ALLOC;
                            end
                        end
                        CMD_INS_AT: begin
                            if (!full && i_position <= r_count) begin
                                priority if (i_position == '0) begin
                                    n_op = OP_PUT_HEAD;
                                end else if (i_position == r_count) begin
                                    n_op = OP_PUT_TAIL;
                                end else begin
                                    n_op = OP_PUT_MID;
                                end
                                n_res_ok = 1'b1;
                                n_state  = S_ALLOC;
                            end
                        end
                        CMD_DELETE: begin
                            if (i_position < r_count) begin
                                n_op     = OP_DELETE;
                                n_res_ok = 1'b1;
                                n_state  = S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (r_fcount != '0) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = r_fhead;
                    n_new       = r_fhead;
                    n_state     = S_ALLOC_WAIT;
                end else begin
                    n_new   = r_fresh[SLOT_W-1:0];
                    n_fresh = r_fresh + COUNT_W'(1);
                    n_state = (r_op == OP_PUT_MID) ? S_WALK : S_WR1;
                end
            end
            S_ALLOC_WAIT: begin
                n_fhead  = i_mem_rsp.link;
                n_fcount = r_fcount - COUNT_W'(1);
                n_state  = (r_op == OP_PUT_MID) ? S_WALK : S_WR1;
            end
            S_WALK: begin
                n_cur = cur_now;
                if (r_steps != '0) begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = cur_now;
                    n_prev      = cur_now;
                    n_pend      = 1'b1;
                    n_steps     = r_steps - COUNT_W'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = (r_op == OP_PUT_MID) ? S_WR1 : S_FETCH;
                end
            end
            S_FETCH: begin
                req.rd_en   = 1'b1;
                req.rd_addr = r_cur;
                n_state     = S_USE;
            end
            S_USE: begin
                if (r_op == OP_READ) begin
                    n_res_rv = i_mem_rsp.value;
                    n_state  = S_RESP;
                end else begin
                    n_nn    = i_mem_rsp.link;
                    n_state = S_WR1;
                end
            end
            S_WR1: begin
                n_state = S_RESP;
                unique case (r_op)
                    OP_PUT_HEAD: begin
                        req.wr_val_en  = 1'b1;
                        req.wr_link_en = 1'b1;
                        req.wr_addr    = r_new;
                        req.wr_val     = r_v;
                        req.wr_link    = (r_count == '0) ? '0 : r_head;
                        n_head         = r_new;
                        if (r_count == '0) begin
                            n_tail = r_new;
                        end
                        n_count = r_count + COUNT_W'(1);
                    end
                    OP_PUT_TAIL: begin
                        req.wr_val_en  = 1'b1;
                        req.wr_link_en = 1'b1;
                        req.wr_addr    = r_new;
                        req.wr_val     = r_v;
                        req.wr_link    = '0;
                        if (r_count == '0) begin
                            n_head  = r_new;
                            n_tail  = r_new;
                            n_count = r_count + COUNT_W'(1);
                        end else begin
                            n_state = S_WR2;
                        end
                    end
                    OP_PUT_MID: begin
                        req.wr_val_en  = 1'b1;
                        req.wr_link_en = 1'b1;
                        req.wr_addr    = r_new;
                        req.wr_val     = r_v;
                        req.wr_link    = r_cur;
                        n_state        = S_WR2;
                    end
                    OP_DELETE: begin
                        req.wr_link_en = 1'b1;
                        n_count        = r_count - COUNT_W'(1);
                        if (r_at_head) begin
                            req.wr_addr = r_cur;
                            req.wr_link = r_fhead;
                            n_fhead     = r_cur;
                            n_fcount    = r_fcount + COUNT_W'(1);
                            if (r_count == COUNT_W'(1)) begin
                                n_head = '0;
                                n_tail = '0;
                            end else begin
                                n_head = r_nn;
                            end
                        end else begin
                            req.wr_addr = r_prev;
                            req.wr_link = r_nn;
                            if (r_cur == r_tail) begin
                                n_tail = r_prev;
                            end
                            n_state = S_WR2;
                        end
                    end
                    OP_READ: begin
                    end
                endcase
            end
            S_WR2: begin
                n_state = S_RESP;
                unique case (r_op)
                    OP_PUT_TAIL: begin
                        req.wr_link_en = 1'b1;
                        req.wr_addr    = r_tail;
                        req.wr_link    = r_new;
                        n_tail         = r_new;
                        n_count        = r_count + COUNT_W'(1);
                    end
                    OP_PUT_MID: begin
                        req.wr_link_en = 1'b1;
                        req.wr_addr    = r_prev;
                        req.wr_link    = r_new;
                        n_count        = r_count + COUNT_W'(1);
                    end
                    OP_DELETE: begin
                        req.wr_link_en = 1'b1;
                        req.wr_addr    = r_cur;
                        req.wr_link    = r_fhead;
                        n_fhead        = r_cur;
                        n_fcount       = r_fcount + COUNT_W'(1);
                    end
                    default: begin
                    end
                endcase
            end
            S_RESP: begin
                o_res.valid = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_res.ok    = r_res_ok;
        o_res.rv    = r_res_rv;
        o_res.count = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_READ;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_fresh  <= '0;
            r_fhead  <= '0;
            r_fcount <= '0;
            r_steps  <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_op     <= n_op;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_fresh  <= n_fresh;
            r_fhead  <= n_fhead;
            r_fcount <= n_fcount;
            r_steps  <= n_steps;
            r_pend   <= n_pend;
        end
        r_at_head <= n_at_head;
        r_cur     <= n_cur;
        r_prev    <= n_prev;
        r_new     <= n_new;
        r_nn      <= n_nn;
        r_v       <= n_v;
        r_res_ok  <= n_res_ok;
        r_res_rv  <= n_res_rv;
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_mem_req  = req;

endmodule

// ===== sv/indexed_linked_list_engine_unit.sv =====
// Top level of the indexed linked list engine: sequencer, node store and result register.
// A request at position p walks p next links; head and tail inserts need no walk, and
// rejected requests go straight to the response.
// The link walk follows one next link per cycle through the link memory.
// One request is in work at a time; while a result waits, the next request's result is held and stalls the input.
// Reset clears the list pointers, counters and control state; the node store needs no clearing.
`include "indexed_linked_list_engine_unit_macros.svh"

module indexed_linked_list_engine_unit import ilst_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [CMD_W-1:0]             i_cmd,
    input  logic [COUNT_W-1:0]           i_position,
    input  logic signed [IO_VALUE_W-1:0] i_item_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_ok,
    output logic signed [IO_VALUE_W-1:0] o_read_value,
    output logic [COUNT_W-1:0]           o_element_count
);

    t_mem_req mem_req;
    t_mem_rsp mem_rsp;
    t_result  res;
    logic     out_free;

    logic                  r_out_valid;
    logic                  r_out_ok;
    logic [IO_VALUE_W-1:0] r_out_rv;
    t_count                r_out_count;

    assign out_free = !r_out_valid || !i_out_stall;

    ilst_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_cmd        (i_cmd),
        .i_position   (i_position),
        .i_item_value (i_item_value),
        .i_out_free   (out_free),
        .o_res        (res),
        .o_mem_req    (mem_req),
        .i_mem_rsp    (mem_rsp)
    );

    ilst_node_mem u_node_mem (
        .i_clk (i_clk),
        .i_req (mem_req),
        .o_rsp (mem_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (res.valid) begin
            r_out_ok    <= res.ok;
            r_out_rv    <= IO_VALUE_W'(res.rv);
            r_out_count <= res.count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ok            = r_out_ok;
    assign o_read_value    = r_out_rv;
    assign o_element_count = r_out_count;

    `ILST_ASSERT_IMPL(a_mem_no_rw_overlap, mem_req.rd_en, !(mem_req.wr_val_en || mem_req.wr_link_en))
    `ILST_ASSERT_IMPL(a_count_bound, o_out_valid, o_element_count <= COUNT_W'(CAPACITY))
    `ILST_ASSERT_NEXT(a_busy_after_request, i_in_valid && !o_in_stall, o_in_stall)
    `ILST_ASSERT_NEXT(a_result_loaded, res.valid, o_out_valid)

endmodule
